// ===== src/nearest_building_distance_unit_macros.svh =====
// Assertion macros for the distance unit sources; only the controller includes them.
`ifndef NEAREST_BUILDING_DISTANCE_UNIT_MACROS_SVH
`define NEAREST_BUILDING_DISTANCE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nbd assertion failed");
`define NBD_ASSERT_IF(lbl, en, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (en) |-> (prop)) \
    else $error("nbd assertion failed");
`else
`define NBD_ASSERT(lbl, prop)
`define NBD_ASSERT_IF(lbl, en, prop)
`endif
`endif

// ===== src/nbd_pkg.sv =====
`default_nettype none
package nbd_pkg;

  localparam int MAX_BUILDINGS_DEF = 64;
  localparam int FRAC_BITS_DEF     = 8;

  localparam int POS_FIELD_W  = 21;
  localparam int EXT_FIELD_W  = 20;
  localparam int SLOT_W       = 6;
  localparam int CELL_W       = 10;
  localparam int COUNT_W      = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 20;
  localparam int DIST_W       = 21;

  localparam logic [CFG_INDEX_W-1:0] CFG_BUILDING_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_SIZE_X    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_SIZE_Y    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_SIZE_Z    = 2'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CELL_W-1:0] CELL_SIZE_RESET = CELL_W'(0);
  localparam logic [EXT_FIELD_W-1:0] SPACING_RESET = 20'd256;

  // Width of the signed position datapath for a given fraction width.
  function automatic int pos_width(input int fb);
    int base;
    base = (fb + CELL_W > POS_FIELD_W) ? fb + CELL_W : POS_FIELD_W;
    return base + 3;
  endfunction

  typedef struct packed {
    logic signed [POS_FIELD_W-1:0] front_x;
    logic signed [POS_FIELD_W-1:0] center_y;
    logic [EXT_FIELD_W-1:0]        length_x;
    logic [EXT_FIELD_W-1:0]        width_y;
    logic [EXT_FIELD_W-1:0]        roof_height;
  } bld_t;

  typedef struct packed {
    logic wr_en;
    logic q_start;
    logic nb_set;
    logic rd_en;
    logic edge_en;
    logic face_en;
    logic sq_en;
    logic acc_clr;
    logic acc_add;
    logic rt_init;
    logic rt_step;
    logic c_take;
    logic c_first;
    logic b_take;
    logic b_first;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic roof;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/nbd_ctrl.sv =====
`default_nettype none
`include "nearest_building_distance_unit_macros.svh"
module nbd_ctrl import nbd_pkg::*; #(
  parameter int MAX_BUILDINGS = MAX_BUILDINGS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int AW            = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               command_i,
  input  wire logic [COUNT_W-1:0] building_count_i,
  input  wire logic               out_stall_i,
  output      logic               out_valid_o,
  input  wire sts_t               sts_i,
  output      cmd_t               cmd_o,
  output      logic [AW-1:0]      addr_o,
  output      logic [1:0]         cand_o,
  output      logic [1:0]         term_o
);

  localparam int CNTW0 = $clog2(MAX_BUILDINGS + 1);
  localparam int CNTW  = (CNTW0 > COUNT_W) ? CNTW0 : COUNT_W;
  localparam int RW    = pos_width(FRAC_BITS);
  localparam int SCW   = $clog2(RW);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EDGE, S_FACE, S_SQ, S_SQF, S_RT, S_CTAKE, S_BTAKE, S_DONE
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] n_q;
  logic [1:0]      cand_q;
  logic [1:0]      term_q;
  logic [SCW-1:0]  step_q;
  logic            out_valid_q;
  logic [CNTW-1:0] limit;
  logic            accept;
  logic            out_free;

  always_comb begin
    limit = (CNTW'(building_count_i) > CNTW'(MAX_BUILDINGS)) ?
            CNTW'(MAX_BUILDINGS) : CNTW'(building_count_i);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign addr_o      = n_q[AW-1:0];
  assign cand_o      = cand_q;
  assign term_o      = term_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_en    = accept && (command_i == CMD_LOAD);
    cmd_o.q_start  = accept && (command_i == CMD_QUERY);
    cmd_o.nb_set   = (limit == '0);
    cmd_o.rd_en    = (state_q == S_FETCH);
    cmd_o.edge_en  = (state_q == S_EDGE);
    cmd_o.face_en  = (state_q == S_FACE);
    cmd_o.sq_en    = (state_q == S_SQ);
    cmd_o.acc_clr  = (state_q == S_SQ) && (term_q == 2'd0);
    cmd_o.acc_add  = (state_q == S_SQ) && (term_q != 2'd0);
    cmd_o.rt_init  = (state_q == S_SQF);
    cmd_o.rt_step  = (state_q == S_RT);
    cmd_o.c_take   = (state_q == S_CTAKE);
    cmd_o.c_first  = (cand_q == 2'd0);
    cmd_o.b_take   = (state_q == S_BTAKE);
    cmd_o.b_first  = (n_q == '0);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      cand_q      <= '0;
      term_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (command_i == CMD_QUERY)) begin
            n_q     <= '0;
            state_q <= (limit == '0) ? S_DONE : S_FETCH;
          end
        end
        S_FETCH: state_q <= S_EDGE;
        S_EDGE:  state_q <= S_FACE;
        S_FACE: begin
          cand_q  <= '0;
          term_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (term_q == 2'd2) begin
            term_q  <= '0;
            state_q <= S_SQF;
          end else begin
            term_q <= term_q + 2'd1;
          end
        end
        S_SQF: begin
          step_q  <= '0;
          state_q <= S_RT;
        end
        S_RT: begin
          step_q <= step_q + SCW'(1);
          if (step_q == SCW'(RW - 1)) begin
            state_q <= S_CTAKE;
          end
        end
        S_CTAKE: begin
          if (sts_i.roof || (cand_q == 2'd3)) begin
            state_q <= S_BTAKE;
          end else begin
            cand_q  <= cand_q + 2'd1;
            term_q  <= '0;
            state_q <= S_SQ;
          end
        end
        S_BTAKE: begin
          if (n_q + CNTW'(1) == limit) begin
            state_q <= S_DONE;
          end else begin
            n_q     <= n_q + CNTW'(1);
            state_q <= S_FETCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A result only appears after the walk has finished.
  `NBD_ASSERT(a_out_after_done, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  // A building above its roof has exactly one candidate.
  `NBD_ASSERT_IF(a_roof_one_cand, (state_q == S_CTAKE) && sts_i.roof, cand_q == 2'd0)
  // The walk never fetches past the loaded count.
  `NBD_ASSERT_IF(a_fetch_in_range, state_q == S_FETCH, n_q < limit)
  // The root sequencer stays within its digit count.
  `NBD_ASSERT_IF(a_step_bound, state_q == S_RT, step_q < SCW'(RW))

endmodule
`default_nettype wire

// ===== src/nbd_dpath.sv =====
`default_nettype none
module nbd_dpath import nbd_pkg::*; #(
  parameter int MAX_BUILDINGS = MAX_BUILDINGS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int AW            = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cmd_t                          cmd_i,
  output      sts_t                          sts_o,
  input  wire logic [AW-1:0]                 addr_i,
  input  wire logic [1:0]                    cand_i,
  input  wire logic [1:0]                    term_i,
  input  wire logic [SLOT_W-1:0]             slot_i,
  input  wire logic signed [POS_FIELD_W-1:0] front_x_i,
  input  wire logic signed [POS_FIELD_W-1:0] center_y_i,
  input  wire logic [EXT_FIELD_W-1:0]        length_x_i,
  input  wire logic [EXT_FIELD_W-1:0]        width_y_i,
  input  wire logic [EXT_FIELD_W-1:0]        roof_height_i,
  input  wire logic [CELL_W-1:0]             cell_i_i,
  input  wire logic [CELL_W-1:0]             cell_j_i,
  input  wire logic [CELL_W-1:0]             cell_k_i,
  input  wire logic [EXT_FIELD_W-1:0]        cell_size_x_i,
  input  wire logic [EXT_FIELD_W-1:0]        cell_size_y_i,
  input  wire logic [EXT_FIELD_W-1:0]        cell_size_z_i,
  output      logic signed [DIST_W-1:0]      min_distance_o,
  output      logic                          no_buildings_o
);

  localparam int PW = pos_width(FRAC_BITS);
  localparam int MW = PW - 1;
  localparam int SW = 2 * MW + 2;
  localparam int RW = SW / 2;
  localparam int BW = RW + 1;
  localparam logic signed [PW-1:0] ONE   = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0]        FMASK = (PW'(1) << FRAC_BITS) - PW'(1);

  function automatic logic signed [PW-1:0] trunc_unit(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v & $signed(~FMASK);
    if (v < 0 && ((v & $signed(FMASK)) != '0)) t = t + ONE;
    return t;
  endfunction

  function automatic logic signed [PW-1:0] absv(input logic signed [PW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  bld_t mem_q [MAX_BUILDINGS];
  bld_t rd_q;

  logic signed [PW-1:0] xc_q, yc_q, zc_q;
  logic signed [PW-1:0] x_q, xl_q, ym_q, yp_q, h_q;
  logic signed [PW-1:0] ex1_q, ex2_q, ey1_q, ey2_q;
  logic                 roof_q;
  logic signed [PW-1:0] term_q [4][3];
  logic [2*MW-1:0]      p_q;
  logic [SW-1:0]        acc_q;
  logic [SW-1:0]        s_q;
  logic [RW+1:0]        rem_q;
  logic [RW-1:0]        root_q;
  logic [RW-1:0]        bb_q;
  logic signed [BW-1:0] gb_q;
  logic                 nb_q;
  logic signed [DIST_W-1:0] out_dist_q;
  logic                 out_nb_q;

  // Edge stage signals.
  logic signed [PW-1:0] bx, by, bl, bhw, bh, bxl, bym, byp;
  assign bx  = PW'($signed(rd_q.front_x));
  assign by  = PW'($signed(rd_q.center_y));
  assign bl  = $signed(PW'(rd_q.length_x));
  assign bhw = $signed(PW'(rd_q.width_y >> 1));
  assign bh  = $signed(PW'(rd_q.roof_height));
  assign bxl = bx + bl;
  assign bym = by - bhw;
  assign byp = by + bhw;

  // Face stage: pick the nearest points for each candidate.
  logic signed [PW-1:0] f_py0, f_py1, f_px, r_px, r_py;
  logic                 f_roof;
  always_comb begin
    f_roof = (zc_q >= h_q);
    f_py0 = yc_q;
    if (yc_q <= ey1_q || yc_q >= ey2_q)
      f_py0 = (absv(ey2_q - yc_q) < absv(ey1_q - yc_q)) ? ey2_q : ey1_q;
    f_py1 = yc_q;
    if (yc_q < ey1_q || yc_q > ey2_q)
      f_py1 = (absv(ey2_q - yc_q) < absv(ey1_q - yc_q)) ? ey2_q : ey1_q;
    f_px = xc_q;
    if (xc_q > ex2_q || xc_q < ex1_q)
      f_px = (absv(ex1_q - xc_q) < absv(ex2_q - xc_q)) ? ex1_q : ex2_q;
    r_px = xc_q;
    r_py = yc_q;
    if (xc_q < ex1_q || xc_q > ex2_q || yc_q < ey1_q || yc_q > ey2_q) begin
      r_px = '0;
      if (xc_q <= ex1_q) begin
        r_px = ex1_q;
        if (yc_q < ey1_q) r_py = ey1_q;
        if (yc_q > ey2_q) r_py = ey2_q;
      end
      if (xc_q >= ex2_q) begin
        r_px = ex2_q;
        if (yc_q <= ey1_q) r_py = ey1_q;
        if (yc_q > ey2_q) r_py = ey2_q;
      end
      if (xc_q > ex1_q && xc_q < ex2_q) begin
        r_px = xc_q;
        if (yc_q <= ey1_q) r_py = ey1_q;
        if (yc_q > ey2_q) r_py = ey2_q;
      end
    end
  end

  logic [MW-1:0]        m_op;
  logic [RW+3:0]        rt_cat, rt_trial;
  assign m_op     = MW'(absv(term_q[cand_i][term_i]));
  assign rt_cat   = {rem_q, s_q[SW-1:SW-2]};
  assign rt_trial = {2'b00, root_q, 2'b01};

  logic signed [BW-1:0] b_clamp, zc_w, bb_w;
  assign zc_w    = BW'(zc_q);
  assign bb_w    = $signed({1'b0, bb_q});
  assign b_clamp = (bb_w > zc_w) ? zc_w : bb_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (32'(slot_i) < MAX_BUILDINGS)) begin
      mem_q[AW'(slot_i)] <= '{front_x: front_x_i, center_y: center_y_i,
                              length_x: length_x_i, width_y: width_y_i,
                              roof_height: roof_height_i};
    end
    if (cmd_i.rd_en) rd_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      xc_q <= $signed((PW'(cell_i_i) << FRAC_BITS) + PW'(cell_size_x_i >> 1));
      yc_q <= $signed((PW'(cell_j_i) << FRAC_BITS) + PW'(cell_size_y_i >> 1));
      zc_q <= $signed((PW'(cell_k_i) << FRAC_BITS) + PW'(cell_size_z_i >> 1)) - ONE;
      nb_q <= cmd_i.nb_set;
    end
    if (cmd_i.edge_en) begin
      x_q   <= bx;
      xl_q  <= bxl;
      ym_q  <= bym;
      yp_q  <= byp;
      h_q   <= bh;
      ex1_q <= trunc_unit(bx);
      ex2_q <= trunc_unit(bxl);
      ey1_q <= trunc_unit(bym);
      ey2_q <= trunc_unit(byp);
    end
    if (cmd_i.face_en) begin
      roof_q <= f_roof;
      if (f_roof) begin
        term_q[0][0] <= xc_q - r_px;
        term_q[0][1] <= yc_q - r_py;
        term_q[0][2] <= zc_q - h_q;
      end else begin
        term_q[0][0] <= xc_q - x_q;
        term_q[0][1] <= yc_q - f_py0;
        term_q[0][2] <= '0;
      end
      term_q[1][0] <= xc_q - xl_q;
      term_q[1][1] <= yc_q - f_py1;
      term_q[1][2] <= '0;
      term_q[2][0] <= xc_q - f_px;
      term_q[2][1] <= yc_q - ym_q;
      term_q[2][2] <= '0;
      term_q[3][0] <= xc_q - f_px;
      term_q[3][1] <= yc_q - yp_q;
      term_q[3][2] <= '0;
    end
    if (cmd_i.sq_en) p_q <= m_op * m_op;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + SW'(p_q);
    // Restoring square root, one result bit per cycle.
    if (cmd_i.rt_init) begin
      s_q    <= acc_q + SW'(p_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      s_q <= s_q << 2;
      if (rt_cat >= rt_trial) begin
        rem_q  <= (RW+2)'(rt_cat - rt_trial);
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= (RW+2)'(rt_cat);
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.c_take && (cmd_i.c_first || root_q < bb_q)) bb_q <= root_q;
    if (cmd_i.b_take && (cmd_i.b_first || b_clamp < gb_q)) gb_q <= b_clamp;
    if (cmd_i.out_load) begin
      out_dist_q <= nb_q ? '0 : gb_q[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_nb_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_nb_q <= nb_q;
    end
  end

  assign sts_o.roof      = roof_q;
  assign min_distance_o  = out_dist_q;
  assign no_buildings_o  = out_nb_q;

endmodule
`default_nettype wire

// ===== src/nearest_building_distance_unit.sv =====
// A load is written into the table when it is accepted. A query with no buildings goes straight
// to the done state. A query walks the table one building at a time: fetch and setup, then per
// candidate squaring of the x, y and z terms on one shared multiplier, a bit-serial root and a
// step to keep the nearest, then a step to fold each building into the running minimum. A
// building below its roof has four candidates, one above it a single candidate.
// One item is worked at a time; loads are taken every cycle while idle.
// Reset (async, active low) resets control and config (count zero, cell sizes 256); the building table is not cleared.
`default_nettype none
module nearest_building_distance_unit import nbd_pkg::*; #(
  parameter int MAX_BUILDINGS = MAX_BUILDINGS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [SLOT_W-1:0]             slot_i,
  input  wire logic signed [POS_FIELD_W-1:0] front_x_i,
  input  wire logic signed [POS_FIELD_W-1:0] center_y_i,
  input  wire logic [EXT_FIELD_W-1:0]        length_x_i,
  input  wire logic [EXT_FIELD_W-1:0]        width_y_i,
  input  wire logic [EXT_FIELD_W-1:0]        roof_height_i,
  input  wire logic [CELL_W-1:0]             cell_i_i,
  input  wire logic [CELL_W-1:0]             cell_j_i,
  input  wire logic [CELL_W-1:0]             cell_k_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [DIST_W-1:0]      min_distance_o,
  output      logic                          no_buildings_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int AW = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;

  logic [COUNT_W-1:0]     bc_q;
  logic [EXT_FIELD_W-1:0] csx_q, csy_q, csz_q;
  cmd_t                   cmd;
  sts_t                   sts;
  logic [AW-1:0]          addr;
  logic [1:0]             cand;
  logic [1:0]             term;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q  <= '0;
      csx_q <= SPACING_RESET;
      csy_q <= SPACING_RESET;
      csz_q <= SPACING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BUILDING_COUNT: bc_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_CELL_SIZE_X:    csx_q <= cfg_data_i;
        CFG_CELL_SIZE_Y:    csy_q <= cfg_data_i;
        CFG_CELL_SIZE_Z:    csz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nbd_ctrl #(
    .MAX_BUILDINGS(MAX_BUILDINGS),
    .FRAC_BITS    (FRAC_BITS),
    .AW           (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .building_count_i(bc_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .addr_o          (addr),
    .cand_o          (cand),
    .term_o          (term)
  );

  nbd_dpath #(
    .MAX_BUILDINGS(MAX_BUILDINGS),
    .FRAC_BITS    (FRAC_BITS),
    .AW           (AW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .addr_i        (addr),
    .cand_i        (cand),
    .term_i        (term),
    .slot_i        (slot_i),
    .front_x_i     (front_x_i),
    .center_y_i    (center_y_i),
    .length_x_i    (length_x_i),
    .width_y_i     (width_y_i),
    .roof_height_i (roof_height_i),
    .cell_i_i      (cell_i_i),
    .cell_j_i      (cell_j_i),
    .cell_k_i      (cell_k_i),
    .cell_size_x_i (csx_q),
    .cell_size_y_i (csy_q),
    .cell_size_z_i (csz_q),
    .min_distance_o(min_distance_o),
    .no_buildings_o(no_buildings_o)
  );

endmodule
`default_nettype wire
